>>> design/scf_pkg.sv
// shared types and constants for the serial command frame responder
`default_nettype none

package scf_pkg;

    localparam int MAX_FRAME_BYTES_DEFAULT = 64;

    localparam logic [7:0] START_BYTE_RESET   = 8'd170;
    localparam logic [7:0] END_BYTE_RESET     = 8'd85;
    localparam logic [7:0] SENSOR_CODE_RESET  = 8'd2;
    localparam logic [7:0] LED_CODE_RESET     = 8'd3;

    localparam logic [7:0] TEMP_LIMIT   = 8'd50;
    localparam logic [7:0] HUM_LIMIT    = 8'd100;
    localparam logic [7:0] TEMP_DEFAULT = 8'd25;
    localparam logic [7:0] HUM_DEFAULT  = 8'd50;

    localparam logic [7:0] LED_CMD_OFF = 8'h00;
    localparam logic [7:0] LED_CMD_ON  = 8'h01;

    localparam logic [7:0] REPLY_ID_0 = 8'h01;
    localparam logic [7:0] REPLY_ID_1 = 8'h03;

    localparam int CFG_INDEX_W = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_BYTE  = 8'd0,
        CFG_END_BYTE    = 8'd1,
        CFG_SENSOR_CODE = 8'd2,
        CFG_LED_CODE    = 8'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] sensor_request_code;
        logic [7:0] led_control_code;
    } cfg_t;

    // values carried by one reply frame
    typedef struct packed {
        logic [7:0] temperature;
        logic [7:0] humidity;
        logic       led;
    } reply_snap_t;

    typedef enum logic [2:0] {
        POS_START = 3'd0,
        POS_ID_0  = 3'd1,
        POS_ID_1  = 3'd2,
        POS_TEMP  = 3'd3,
        POS_HUM   = 3'd4,
        POS_LED   = 3'd5,
        POS_END   = 3'd6
    } reply_pos_t;

endpackage

`default_nettype wire

>>> design/scf_parser.sv
// frame parser: byte counter, held header fields and the sensor and led state
`default_nettype none

module scf_parser #(
    parameter int MAX_FRAME_BYTES = scf_pkg::MAX_FRAME_BYTES_DEFAULT
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  fire,
    input  wire [7:0]            rx_byte,
    input  wire                  sensor_read_ok,
    input  wire                  sensor_valid,
    input  wire [7:0]            sensor_temperature,
    input  wire [7:0]            sensor_humidity,
    input  wire scf_pkg::cfg_t   cfg,
    output logic                 reply_fire,
    output scf_pkg::reply_snap_t reply_snap
);

    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [7:0] LEN_LIMIT = 8'(MAX_FRAME_BYTES - 4);

    logic [CW-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [7:0]    type_reg, type_next;
    logic [7:0]    len_reg, len_next;
    logic [7:0]    first_reg, first_next;
    logic [7:0]    temp_reg, temp_next;
    logic [7:0]    hum_reg, hum_next;
    logic          led_reg, led_next;
    logic          good;

    always_comb
    begin
        cnt_inc    = cnt_reg + CW'(1);
        cnt_next   = cnt_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        first_next = first_reg;
        temp_next  = temp_reg;
        hum_next   = hum_reg;
        led_next   = led_reg;
        good       = 1'b0;
        if (fire)
        begin
            if (cnt_reg == '0)
            begin
                if (rx_byte == cfg.start_byte)
                    cnt_next = CW'(1);
            end
            else if (cnt_reg >= CW'(MAX_FRAME_BYTES))
            begin
                cnt_next = '0;
            end
            else
            begin
                cnt_next = cnt_inc;
                if (cnt_inc == CW'(2))
                begin
                    type_next = rx_byte;
                end
                else if (cnt_inc == CW'(3))
                begin
                    len_next = rx_byte;
                    if (rx_byte > LEN_LIMIT)
                        cnt_next = '0;
                end
                else
                begin
                    if (cnt_inc == CW'(4))
                        first_next = rx_byte;
                    if (9'(cnt_inc) == ({1'b0, len_reg} + 9'd4))
                    begin
                        cnt_next = '0;
                        good     = (rx_byte == cfg.end_byte);
                    end
                end
            end
        end

        if (good)
        begin
            if (type_reg == cfg.sensor_request_code && len_reg == 8'd0)
            begin
                if (sensor_read_ok && sensor_valid)
                begin
                    temp_next = (sensor_temperature > scf_pkg::TEMP_LIMIT) ?
                                scf_pkg::TEMP_LIMIT : sensor_temperature;
                    hum_next  = (sensor_humidity > scf_pkg::HUM_LIMIT) ?
                                scf_pkg::HUM_LIMIT : sensor_humidity;
                end
                else
                begin
                    temp_next = scf_pkg::TEMP_DEFAULT;
                    hum_next  = scf_pkg::HUM_DEFAULT;
                end
            end
            else if (type_reg == cfg.led_control_code && len_reg == 8'd1)
            begin
                if (first_reg == scf_pkg::LED_CMD_OFF)
                    led_next = 1'b0;
                else if (first_reg == scf_pkg::LED_CMD_ON)
                    led_next = 1'b1;
            end
        end
    end

    assign reply_fire             = good;
    assign reply_snap.temperature = temp_next;
    assign reply_snap.humidity    = hum_next;
    assign reply_snap.led         = led_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            temp_reg <= scf_pkg::TEMP_DEFAULT;
            hum_reg  <= scf_pkg::HUM_DEFAULT;
            led_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            temp_reg <= temp_next;
            hum_reg  <= hum_next;
            led_reg  <= led_next;
        end
    end

    // header fields are written before any read
    always_ff @(posedge clk)
    begin
        type_reg  <= type_next;
        len_reg   <= len_next;
        first_reg <= first_next;
    end

endmodule

`default_nettype wire

>>> design/scf_reply.sv
// reply serializer: one active reply plus one waiting reply, seven bytes each
`default_nettype none

module scf_reply (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       load,
    input  wire scf_pkg::reply_snap_t snap,
    input  wire scf_pkg::cfg_t        cfg,
    input  wire                       out_ready,
    output logic                      out_valid,
    output logic [7:0]                tx_byte,
    output logic                      tx_last,
    output logic                      led_on,
    output logic                      full
);

    logic                 act_reg, act_next;
    logic                 pend_reg, pend_next;
    scf_pkg::reply_pos_t  pos_reg, pos_next;
    scf_pkg::reply_snap_t cur_reg, cur_next;
    scf_pkg::reply_snap_t wait_reg, wait_next;
    logic                 done;
    logic                 ser_free;

    assign done     = act_reg && out_ready && (pos_reg == scf_pkg::POS_END);
    assign ser_free = !act_reg || done;

    always_comb
    begin
        act_next  = act_reg;
        pend_next = pend_reg;
        pos_next  = pos_reg;
        cur_next  = cur_reg;
        wait_next = wait_reg;
        if (act_reg && out_ready)
        begin
            if (done)
            begin
                pos_next = scf_pkg::POS_START;
                act_next = 1'b0;
            end
            else
            begin
                pos_next = scf_pkg::reply_pos_t'(pos_reg + 3'd1);
            end
        end
        if (done && pend_reg)
        begin
            act_next  = 1'b1;
            cur_next  = wait_reg;
            pend_next = 1'b0;
        end
        if (load)
        begin
            if (ser_free && !pend_reg)
            begin
                act_next = 1'b1;
                pos_next = scf_pkg::POS_START;
                cur_next = snap;
            end
            else
            begin
                pend_next = 1'b1;
                wait_next = snap;
            end
        end
    end

    always_comb
    begin
        case (pos_reg)
            scf_pkg::POS_START: tx_byte = cfg.start_byte;
            scf_pkg::POS_ID_0:  tx_byte = scf_pkg::REPLY_ID_0;
            scf_pkg::POS_ID_1:  tx_byte = scf_pkg::REPLY_ID_1;
            scf_pkg::POS_TEMP:  tx_byte = cur_reg.temperature;
            scf_pkg::POS_HUM:   tx_byte = cur_reg.humidity;
            scf_pkg::POS_LED:   tx_byte = {7'd0, cur_reg.led};
            scf_pkg::POS_END:   tx_byte = cfg.end_byte;
            default:            tx_byte = cfg.end_byte;
        endcase
    end

    assign out_valid = act_reg;
    assign tx_last   = (pos_reg == scf_pkg::POS_END);
    assign led_on    = cur_reg.led;
    assign full      = pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= 1'b0;
            pend_reg <= 1'b0;
            pos_reg  <= scf_pkg::POS_START;
        end
        else
        begin
            act_reg  <= act_next;
            pend_reg <= pend_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        wait_reg <= wait_next;
    end

endmodule

`default_nettype wire

>>> design/serial_command_frame_responder.sv
// top level: config registers, frame parser and reply serializer
// reply: a good closing byte loads its snapshot into the serializer, or into the waiting slot while a reply is busy
// throughput: one received byte per cycle while in_ready is high; a reply is seven bytes,
//   and in_ready drops only while a second finished reply waits behind the one being sent
// sustained: a minimum four-byte frame still gets a seven-byte reply, so the one output port sets the pace
// reset: rst_n empties the reply queue, zeroes the byte counter, loads the config reset
//   values, readings 25 and 50 and led off; no clearing pass
`default_nettype none

module serial_command_frame_responder #(
    parameter int MAX_FRAME_BYTES = scf_pkg::MAX_FRAME_BYTES_DEFAULT
) (
    input  wire                            clk,
    input  wire                            rst_n,
    // config write channel
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire [scf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire [7:0]                      cfg_data,
    // received byte channel
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire [7:0]                      rx_byte,
    input  wire                            sensor_read_ok,
    input  wire                            sensor_valid,
    input  wire [7:0]                      sensor_temperature,
    input  wire [7:0]                      sensor_humidity,
    // reply byte channel
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic [7:0]                     tx_byte,
    output logic                           tx_last,
    output logic                           led_on
);

    scf_pkg::cfg_t        cfg_reg, cfg_next;
    scf_pkg::reply_snap_t snap;
    logic                 in_fire;
    logic                 reply_fire;
    logic                 reply_full;

    // config writes always complete; an index past the list is dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                scf_pkg::CFG_START_BYTE:  cfg_next.start_byte          = cfg_data;
                scf_pkg::CFG_END_BYTE:    cfg_next.end_byte            = cfg_data;
                scf_pkg::CFG_SENSOR_CODE: cfg_next.sensor_request_code = cfg_data;
                scf_pkg::CFG_LED_CODE:    cfg_next.led_control_code    = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte          <= scf_pkg::START_BYTE_RESET;
            cfg_reg.end_byte            <= scf_pkg::END_BYTE_RESET;
            cfg_reg.sensor_request_code <= scf_pkg::SENSOR_CODE_RESET;
            cfg_reg.led_control_code    <= scf_pkg::LED_CODE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // a byte is taken whenever a reply slot is free for whatever it may close
    assign in_ready = !reply_full;
    assign in_fire  = in_valid && in_ready;

    // parser updates frame state on each transfer and flags a good closing byte
    scf_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .clk                (clk),
        .rst_n              (rst_n),
        .fire               (in_fire),
        .rx_byte            (rx_byte),
        .sensor_read_ok     (sensor_read_ok),
        .sensor_valid       (sensor_valid),
        .sensor_temperature (sensor_temperature),
        .sensor_humidity    (sensor_humidity),
        .cfg                (cfg_reg),
        .reply_fire         (reply_fire),
        .reply_snap         (snap)
    );

    // serializer holds a snapshot of the state per reply, so later frames
    // cannot disturb a reply that is still going out
    scf_reply u_reply (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (reply_fire),
        .snap      (snap),
        .cfg       (cfg_reg),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .tx_byte   (tx_byte),
        .tx_last   (tx_last),
        .led_on    (led_on),
        .full      (reply_full)
    );

    // input only stalls behind a reply in flight
    assert property (@(posedge clk) disable iff (!rst_n) !in_ready |-> out_valid)
        else $error("input stalled with no reply in flight");

    // led level is fixed across one reply frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !tx_last |=> $stable(led_on))
        else $error("led level changed inside a reply");

    // the closing reply byte is the end byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_last |-> tx_byte == cfg_reg.end_byte)
        else $error("last reply byte is not the end byte");

endmodule

`default_nettype wire

>>> dv/frame_reply_checker.sv
// checker: predicts the reply bytes of the frame responder and compares them at the output
module frame_reply_checker #(
    parameter int FRAME_LIMIT = scf_pkg::MAX_FRAME_BYTES_DEFAULT
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_valid,
    input  wire                            cfg_ready,
    input  wire [scf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire [7:0]                      cfg_data,
    input  wire                            in_valid,
    input  wire                            in_ready,
    input  wire [7:0]                      rx_byte,
    input  wire                            sensor_read_ok,
    input  wire                            sensor_valid,
    input  wire [7:0]                      sensor_temperature,
    input  wire [7:0]                      sensor_humidity,
    input  wire                            out_valid,
    input  wire                            out_ready,
    input  wire [7:0]                      tx_byte,
    input  wire                            tx_last,
    input  wire                            led_on,
    output int                             mismatches,
    output int                             replies_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       led;
    } reply_beat_t;

    reply_beat_t reply_bytes_due[$];

    scf_pkg::cfg_t regs;
    logic [8:0]    frame_count;
    logic [7:0]    held_type;
    logic [7:0]    held_length;
    logic [7:0]    held_first;
    logic [7:0]    temp_now;
    logic [7:0]    hum_now;
    logic          led_now;
    int            error_total;

    // act on a good frame, then queue its seven reply bytes
    task automatic answer_frame(input logic ok, input logic vld,
                                input logic [7:0] temp, input logic [7:0] hum);
        logic [7:0]  reply [7];
        reply_beat_t beat;
        int          k;
        if (held_type == regs.sensor_request_code && held_length == 8'd0) begin
            if (ok && vld) begin
                temp_now = (temp > scf_pkg::TEMP_LIMIT) ? scf_pkg::TEMP_LIMIT : temp;
                hum_now  = (hum > scf_pkg::HUM_LIMIT) ? scf_pkg::HUM_LIMIT : hum;
            end else begin
                temp_now = scf_pkg::TEMP_DEFAULT;
                hum_now  = scf_pkg::HUM_DEFAULT;
            end
        end else if (held_type == regs.led_control_code && held_length == 8'd1) begin
            if (held_first == scf_pkg::LED_CMD_OFF)
                led_now = 1'b0;
            else if (held_first == scf_pkg::LED_CMD_ON)
                led_now = 1'b1;
        end
        reply[scf_pkg::POS_START] = regs.start_byte;
        reply[scf_pkg::POS_ID_0]  = scf_pkg::REPLY_ID_0;
        reply[scf_pkg::POS_ID_1]  = scf_pkg::REPLY_ID_1;
        reply[scf_pkg::POS_TEMP]  = temp_now;
        reply[scf_pkg::POS_HUM]   = hum_now;
        reply[scf_pkg::POS_LED]   = {7'd0, led_now};
        reply[scf_pkg::POS_END]   = regs.end_byte;
        for (k = 0; k < 7; k++) begin
            beat.data = reply[k];
            beat.last = (k == scf_pkg::POS_END);
            beat.led  = led_now;
            reply_bytes_due.push_back(beat);
        end
    endtask

    // frame parser: one received byte per call
    task automatic parse_rx_byte(input logic [7:0] b, input logic ok, input logic vld,
                                 input logic [7:0] temp, input logic [7:0] hum);
        logic [8:0] frame_total;
        if (frame_count == 9'd0) begin
            if (b == regs.start_byte)
                frame_count = 9'd1;
        end else if (frame_count >= FRAME_LIMIT) begin
            frame_count = 9'd0;
        end else begin
            frame_count = frame_count + 9'd1;
            if (frame_count == 9'd2) begin
                held_type = b;
            end else if (frame_count == 9'd3) begin
                held_length = b;
                frame_total = {1'b0, b} + 9'd4;
                if (frame_total > FRAME_LIMIT)
                    frame_count = 9'd0;
            end else begin
                if (frame_count == 9'd4)
                    held_first = b;
                frame_total = {1'b0, held_length} + 9'd4;
                if (frame_count == frame_total) begin
                    frame_count = 9'd0;
                    if (b == regs.end_byte)
                        answer_frame(ok, vld, temp, hum);
                end
            end
        end
    endtask

    task automatic check_reply_beat();
        reply_beat_t due;
        if (reply_bytes_due.size() == 0) begin
            $display("%0t: reply byte %02h arrived with nothing expected", $time, tx_byte);
            error_total++;
        end else begin
            due = reply_bytes_due.pop_front();
            if (tx_byte !== due.data) begin
                $display("%0t: tx_byte expected %02h actual %02h", $time, due.data, tx_byte);
                error_total++;
            end
            if (tx_last !== due.last) begin
                $display("%0t: tx_last expected %0b actual %0b", $time, due.last, tx_last);
                error_total++;
            end
            if (led_on !== due.led) begin
                $display("%0t: led_on expected %0b actual %0b", $time, due.led, led_on);
                error_total++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            regs.start_byte          = scf_pkg::START_BYTE_RESET;
            regs.end_byte            = scf_pkg::END_BYTE_RESET;
            regs.sensor_request_code = scf_pkg::SENSOR_CODE_RESET;
            regs.led_control_code    = scf_pkg::LED_CODE_RESET;
            frame_count              = 9'd0;
            held_type                = 8'd0;
            held_length              = 8'd0;
            held_first               = 8'd0;
            temp_now                 = scf_pkg::TEMP_DEFAULT;
            hum_now                  = scf_pkg::HUM_DEFAULT;
            led_now                  = 1'b0;
            error_total              = 0;
            reply_bytes_due.delete();
            mismatches  <= 0;
            replies_due <= 0;
        end else begin
            // a new reply only shows after its closing byte, so pop before push
            if (out_valid && out_ready)
                check_reply_beat();
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    scf_pkg::CFG_START_BYTE:  regs.start_byte          = cfg_data;
                    scf_pkg::CFG_END_BYTE:    regs.end_byte            = cfg_data;
                    scf_pkg::CFG_SENSOR_CODE: regs.sensor_request_code = cfg_data;
                    scf_pkg::CFG_LED_CODE:    regs.led_control_code    = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                parse_rx_byte(rx_byte, sensor_read_ok, sensor_valid,
                              sensor_temperature, sensor_humidity);
            mismatches  <= error_total;
            replies_due <= reply_bytes_due.size();
        end
    end

endmodule

>>> dv/testbench.sv
// testbench top: stimulus, idling phases, watchdog and verdict for the frame responder
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles without any transfer before the run is declared hung
    localparam int WATCHDOG_LIMIT = 1000;
    // idle cycles after the last reply byte before the next phase starts
    localparam int SETTLE_CYCLES  = 8;
    // longest sender gap in cycles
    localparam int MAX_GAP        = 30;
    // random received bytes per phase
    localparam int PHASE_BYTES    = 95;
    // indexes past the four registers, writes there must be ignored
    localparam logic [scf_pkg::CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 8'd4;
    localparam logic [scf_pkg::CFG_INDEX_W-1:0] CFG_TOP_INDEX   = 8'hFF;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [scf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]                      cfg_data = 8'd0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [7:0]                      rx_byte = 8'd0;
    logic                            sensor_read_ok = 1'b0;
    logic                            sensor_valid = 1'b0;
    logic [7:0]                      sensor_temperature = 8'd0;
    logic [7:0]                      sensor_humidity = 8'd0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [7:0]                      tx_byte;
    logic                            tx_last;
    logic                            led_on;

    int mismatches;
    int replies_due;

    // idling knobs, percent of cycles
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    // register values as last written, used to build frames
    logic [7:0] cur_start  = scf_pkg::START_BYTE_RESET;
    logic [7:0] cur_end    = scf_pkg::END_BYTE_RESET;
    logic [7:0] cur_sensor = scf_pkg::SENSOR_CODE_RESET;
    logic [7:0] cur_led    = scf_pkg::LED_CODE_RESET;

    // every received byte transfer counts, noise and cut-off frames too
    int frame_bytes_sent = 0;
    int quiet_cycles = 0;

    serial_command_frame_responder uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .rx_byte            (rx_byte),
        .sensor_read_ok     (sensor_read_ok),
        .sensor_valid       (sensor_valid),
        .sensor_temperature (sensor_temperature),
        .sensor_humidity    (sensor_humidity),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .tx_byte            (tx_byte),
        .tx_last            (tx_last),
        .led_on             (led_on)
    );

    // predicts replies from the observed transfers and counts mismatches
    frame_reply_checker reply_watch (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .rx_byte            (rx_byte),
        .sensor_read_ok     (sensor_read_ok),
        .sensor_valid       (sensor_valid),
        .sensor_temperature (sensor_temperature),
        .sensor_humidity    (sensor_humidity),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .tx_byte            (tx_byte),
        .tx_last            (tx_last),
        .led_on             (led_on),
        .mismatches         (mismatches),
        .replies_due        (replies_due)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // receiver: stall decided fresh every cycle
    always @(posedge clk) begin
        out_ready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
    end

    // watchdog: any transfer on any channel restarts the count
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // one register write; valid is left high so back-to-back writes never toggle it
    task automatic write_reg(input logic [scf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            scf_pkg::CFG_START_BYTE:  cur_start  = val;
            scf_pkg::CFG_END_BYTE:    cur_end    = val;
            scf_pkg::CFG_SENSOR_CODE: cur_sensor = val;
            scf_pkg::CFG_LED_CODE:    cur_led    = val;
            default: ;
        endcase
    endtask

    // all four registers plus one write to an unused index
    task automatic load_registers(input logic [7:0] s, input logic [7:0] e,
                                  input logic [7:0] sc, input logic [7:0] lc,
                                  input logic [scf_pkg::CFG_INDEX_W-1:0] spare_idx);
        write_reg(scf_pkg::CFG_START_BYTE, s);
        write_reg(scf_pkg::CFG_END_BYTE, e);
        write_reg(scf_pkg::CFG_SENSOR_CODE, sc);
        write_reg(scf_pkg::CFG_LED_CODE, lc);
        write_reg(spare_idx, 8'($urandom_range(255)));
        cfg_valid <= 1'b0;
    endtask

    // one received byte transfer, with a random gap ahead of it
    task automatic send_rx(input logic [7:0] b, input logic ok, input logic vld,
                           input logic [7:0] temp, input logic [7:0] hum);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid           <= 1'b1;
        rx_byte            <= b;
        sensor_read_ok     <= ok;
        sensor_valid       <= vld;
        sensor_temperature <= temp;
        sensor_humidity    <= hum;
        do @(posedge clk); while (!in_ready);
        frame_bytes_sent++;
    endtask

    // byte whose sensor fields do not matter, so they get noise
    task automatic send_plain(input logic [7:0] b);
        send_rx(b, 1'($urandom_range(1)), 1'($urandom_range(1)),
                8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    // start, type, length, payload, closing byte; an overlong length stops after itself
    task automatic send_frame(input logic [7:0] ftype, input int len, input logic [7:0] first,
                              input bit good_end, input logic ok, input logic vld,
                              input logic [7:0] temp, input logic [7:0] hum);
        int k;
        send_plain(cur_start);
        send_plain(ftype);
        send_plain(8'(len));
        if (len + 4 <= scf_pkg::MAX_FRAME_BYTES_DEFAULT) begin
            for (k = 0; k < len; k++)
                send_plain((k == 0) ? first : 8'($urandom_range(255)));
            send_rx(good_end ? cur_end : 8'($urandom_range(255)), ok, vld, temp, hum);
        end
    endtask

    // sensor value at or below, at or above its clamp limit, or anywhere in the byte range
    function automatic logic [7:0] pick_reading(input logic [7:0] limit);
        case ($urandom_range(3))
            0:       return 8'($urandom_range(int'(limit)));
            1:       return limit;
            2:       return 8'($urandom_range(255, int'(limit) + 1));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // mostly well-formed frames with random content, some noise and cut-off frames
    task automatic random_frame();
        int         pick;
        int         kind;
        int         len;
        int         n;
        logic [7:0] ftype;
        logic [7:0] first;
        pick = $urandom_range(99);
        if (pick < 6) begin
            // line noise while hunting
            n = $urandom_range(3, 1);
            repeat (n) send_plain(8'($urandom_range(255)));
        end else if (pick < 11) begin
            // frame cut short, the next frame's bytes land inside it
            len = $urandom_range(8, 3);
            n = $urandom_range(len - 1, 1);
            send_plain(cur_start);
            send_plain(8'($urandom_range(255)));
            send_plain(8'(len));
            repeat (n) send_plain(8'($urandom_range(255)));
        end else begin
            kind  = $urandom_range(19);
            first = 8'($urandom_range(255));
            if (kind < 8) begin
                ftype = cur_sensor;
                len = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0;
            end else if (kind < 14) begin
                ftype = cur_led;
                len = ($urandom_range(9) == 0) ? 2 * $urandom_range(1) : 1;
                case ($urandom_range(3))
                    0:       first = scf_pkg::LED_CMD_OFF;
                    1:       first = scf_pkg::LED_CMD_ON;
                    default: ;
                endcase
            end else if (kind < 19) begin
                ftype = 8'($urandom_range(255));
                len = $urandom_range(8);
            end else begin
                // long frame near the size limit, or one the length byte drops
                ftype = 8'($urandom_range(255));
                len = $urandom_range(1) ? $urandom_range(60, 50) : $urandom_range(255, 61);
            end
            send_frame(ftype, len, first, $urandom_range(99) < 88,
                       1'($urandom_range(9) != 0), 1'($urandom_range(9) != 0),
                       pick_reading(scf_pkg::TEMP_LIMIT), pick_reading(scf_pkg::HUM_LIMIT));
        end
    endtask

    task automatic random_traffic(input int byte_budget);
        frame_bytes_sent = 0;
        while (frame_bytes_sent < byte_budget)
            random_frame();
    endtask

    // stop sending, wait for every reply byte, then let the parser settle
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (replies_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values, no idling; directed cases first
        send_plain(8'h5A);                                          // ignored while hunting
        send_frame(cur_sensor, 0, 8'h00, 1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF); // both clamp
        send_frame(cur_led, 1, scf_pkg::LED_CMD_ON, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0);
        send_frame(cur_led, 1, 8'h02, 1'b1, 1'b1, 1'b1, 8'd0, 8'd0);   // led unchanged
        send_frame(cur_sensor, 0, 8'h00, 1'b1, 1'b0, 1'b1, 8'd30, 8'd40); // failed read
        send_frame(cur_sensor, 255, 8'h00, 1'b1, 1'b1, 1'b1, 8'd0, 8'd0); // overlong
        // wrong end byte
        send_frame(cur_led, 1, scf_pkg::LED_CMD_OFF, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0);
        random_traffic(PHASE_BYTES);
        drain();

        // low extremes for start and led code, high for end and sensor code; sender idles
        load_registers(8'h00, 8'hFF, 8'hFF, 8'h00, CFG_SPARE_INDEX);
        sender_idle_pct = 46;
        random_traffic(PHASE_BYTES);
        drain();

        // opposite extremes; receiver stalls
        load_registers(8'hFF, 8'h00, 8'h00, 8'hFF, CFG_TOP_INDEX);
        sender_idle_pct = 0;
        receiver_stall_pct <= 46;
        random_traffic(PHASE_BYTES);
        drain();

        // random register values; both sides idle
        load_registers(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 8'($urandom_range(255)), CFG_SPARE_INDEX);
        sender_idle_pct = 25;
        receiver_stall_pct <= 25;
        random_traffic(PHASE_BYTES);
        drain();

        if (mismatches == 0 && replies_due == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
